// ===== hdl/afc_pkg.sv =====
// Shared constants and types for the box versus frustum culling block.
`default_nettype none
package afc_pkg;

   localparam int ROW_COUNT   = 4;
   localparam int PLANE_COUNT = 6;
   localparam int ENTRY_PITCH = 16;
   localparam int ADDR_BITS   = 5;
   localparam int DATA_BITS   = 64;

   typedef enum logic [1:0] {
      REG_ROW_0 = 2'd0,
      REG_ROW_1 = 2'd1,
      REG_ROW_2 = 2'd2,
      REG_ROW_3 = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      PLANE_LEFT   = 3'd0,
      PLANE_RIGHT  = 3'd1,
      PLANE_BOTTOM = 3'd2,
      PLANE_TOP    = 3'd3,
      PLANE_NEAR   = 3'd4,
      PLANE_FAR    = 3'd5,
      PLANE_NONE   = 3'd6
   } plane_code_type;

endpackage
`default_nettype wire

// ===== hdl/afc_plane_regs.sv =====
// Matrix row registers on the APB port and the six clip planes derived from them.
`default_nettype none
module afc_plane_regs
   import afc_pkg::*;
#(
   parameter int EW = 16,
   parameter int PW = 17
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [ADDR_BITS-1:0]              paddr,
   input  wire logic [DATA_BITS-1:0]              pwdata,
   output logic      [DATA_BITS-1:0]              prdata,
   output logic                                   pready,
   output logic      [PLANE_COUNT-1:0][3:0][PW-1:0] plane_coef
);

   logic [ROW_COUNT-1:0][DATA_BITS-1:0]      matrix_ff, matrix_in;
   logic [PLANE_COUNT-1:0][3:0][PW-1:0]      plane_ff, plane_in;
   logic                                     wr_en;
   reg_index_type                            wr_index;

   assign pready   = 1'b1;
   assign wr_en    = psel & penable & pwrite;
   assign wr_index = reg_index_type'(paddr[ADDR_BITS-1:ADDR_BITS-2]);
   assign prdata   = matrix_ff[paddr[ADDR_BITS-1:ADDR_BITS-2]];

   always_comb begin
      matrix_in = matrix_ff;
      if (wr_en) begin
         unique case (wr_index)
            REG_ROW_0: matrix_in[0] = pwdata;
            REG_ROW_1: matrix_in[1] = pwdata;
            REG_ROW_2: matrix_in[2] = pwdata;
            REG_ROW_3: matrix_in[3] = pwdata;
            default:   matrix_in    = matrix_ff;
         endcase
      end
   end

   // plane 2r+1 = row3 - row r, plane 2r = row3 + row r; computed from the
   // next row values so the planes are current at the same edge as the write
   always_comb begin
      logic signed [PW-1:0] r3_e;
      logic signed [PW-1:0] src_e;
      r3_e  = '0;
      src_e = '0;
      for (int k = 0; k < PLANE_COUNT; k++) begin
         for (int c = 0; c < 4; c++) begin
            r3_e  = PW'(signed'(matrix_in[3][c*ENTRY_PITCH +: EW]));
            src_e = PW'(signed'(matrix_in[k/2][c*ENTRY_PITCH +: EW]));
            if ((k % 2) == 1) begin
               plane_in[k][c] = r3_e - src_e;
            end else begin
               plane_in[k][c] = r3_e + src_e;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff <= '0;
         plane_ff  <= '0;
      end else begin
         matrix_ff <= matrix_in;
         plane_ff  <= plane_in;
      end
   end

   assign plane_coef = plane_ff;

endmodule
`default_nettype wire

// ===== hdl/afc_plane_test.sv =====
// P-vertex test of one box against one clip plane.
`default_nettype none
module afc_plane_test #(
   parameter int COORD_BITS = 16,
   parameter int PW         = 17
) (
   input  wire logic [3:0][PW-1:0]         coef,
   input  wire logic [2:0][COORD_BITS-1:0] box_lo,
   input  wire logic [2:0][COORD_BITS-1:0] box_hi,
   output logic                            reject
);

   localparam int PRW = PW + COORD_BITS;
   localparam int SW  = PRW + 2;

   logic signed [PRW-1:0] prod [3];
   logic signed [SW-1:0]  plane_dist;

   always_comb begin
      logic signed [PW-1:0]         a;
      logic signed [COORD_BITS-1:0] x;
      a = '0;
      x = '0;
      for (int c = 0; c < 3; c++) begin
         a = signed'(coef[c]);
         x = a[PW-1] ? signed'(box_lo[c]) : signed'(box_hi[c]);
         prod[c] = PRW'(a) * PRW'(x);
      end
      plane_dist = SW'(signed'(coef[3])) + SW'(prod[0]) + SW'(prod[1]) + SW'(prod[2]);
   end

   assign reject = plane_dist[SW-1];

endmodule
`default_nettype wire

// ===== hdl/aabb_frustum_cull.sv =====
// Top level: box versus view frustum culling, one box per clock.
// One box is taken in every clock (busy is low except right after reset). A
// request accepted at one edge is registered in the box registers, tested
// against all six planes in parallel in the next cycle, registered again in
// the result register and strobed on rsp_strobe for exactly one cycle. One
// result per cycle is sustained by the 18 parallel multipliers. The receiver
// cannot stall. Clip planes are rebuilt at the same edge as a matrix row
// write. Rows sit at byte addresses 0, 8, 16 and 24.
`default_nettype none
module aabb_frustum_cull
   import afc_pkg::*;
#(
   parameter int COORD_BITS = 16,
   parameter int COEF_BITS  = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [COORD_BITS-1:0] req_box_min_x,
   input  wire logic [COORD_BITS-1:0] req_box_min_y,
   input  wire logic [COORD_BITS-1:0] req_box_min_z,
   input  wire logic [COORD_BITS-1:0] req_box_max_x,
   input  wire logic [COORD_BITS-1:0] req_box_max_y,
   input  wire logic [COORD_BITS-1:0] req_box_max_z,
   output logic                       rsp_strobe,
   output logic                       rsp_visible,
   output logic [2:0]                 rsp_rejecting_plane,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [ADDR_BITS-1:0]  paddr,
   input  wire logic [DATA_BITS-1:0]  pwdata,
   output logic      [DATA_BITS-1:0]  prdata,
   output logic                       pready
);

   localparam int EW = (COEF_BITS < ENTRY_PITCH) ? COEF_BITS : ENTRY_PITCH;
   localparam int PW = EW + 1;

   logic [PLANE_COUNT-1:0][3:0][PW-1:0] plane_coef;
   logic [2:0][COORD_BITS-1:0]          box_lo_ff, box_hi_ff;
   logic                                req_valid_ff;
   logic                                ready_ff;
   logic [PLANE_COUNT-1:0]              reject;
   plane_code_type                      rej_in;
   plane_code_type                      rej_ff;
   logic                                rsp_strobe_ff;
   logic                                accept;

   assign busy   = ~ready_ff;
   assign accept = start & ready_ff;

   afc_plane_regs #(
      .EW (EW),
      .PW (PW)
   ) u_regs (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .plane_coef (plane_coef)
   );

   for (genvar k = 0; k < PLANE_COUNT; k++) begin : g_plane
      afc_plane_test #(
         .COORD_BITS (COORD_BITS),
         .PW         (PW)
      ) u_test (
         .coef   (plane_coef[k]),
         .box_lo (box_lo_ff),
         .box_hi (box_hi_ff),
         .reject (reject[k])
      );
   end

   // lowest failing plane wins
   always_comb begin
      rej_in = PLANE_NONE;
      for (int k = PLANE_COUNT - 1; k >= 0; k--) begin
         if (reject[k]) begin
            rej_in = plane_code_type'(3'(k));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff      <= 1'b0;
         req_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         ready_ff      <= 1'b1;
         req_valid_ff  <= accept;
         rsp_strobe_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         box_lo_ff <= {req_box_min_z, req_box_min_y, req_box_min_x};
         box_hi_ff <= {req_box_max_z, req_box_max_y, req_box_max_x};
      end
      rej_ff <= rej_in;
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_visible         = (rej_ff == PLANE_NONE);
   assign rsp_rejecting_plane = rej_ff;

endmodule
`default_nettype wire

// ===== bench/tb_aabb_frustum_cull.sv =====
// Self-checking bench for the box versus frustum culling block.
`default_nettype none
module tb_aabb_frustum_cull
   import afc_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_W = 16;

   typedef struct packed {
      logic signed [COORD_W-1:0] min_x;
      logic signed [COORD_W-1:0] min_y;
      logic signed [COORD_W-1:0] min_z;
      logic signed [COORD_W-1:0] max_x;
      logic signed [COORD_W-1:0] max_y;
      logic signed [COORD_W-1:0] max_z;
   } box_t;

   typedef struct packed {
      logic           visible;
      plane_code_type plane;
   } cull_t;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [COORD_W-1:0]   req_box_min_x = '0;
   logic [COORD_W-1:0]   req_box_min_y = '0;
   logic [COORD_W-1:0]   req_box_min_z = '0;
   logic [COORD_W-1:0]   req_box_max_x = '0;
   logic [COORD_W-1:0]   req_box_max_y = '0;
   logic [COORD_W-1:0]   req_box_max_z = '0;
   logic                 rsp_strobe;
   logic                 rsp_visible;
   logic [2:0]           rsp_rejecting_plane;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [ADDR_BITS-1:0] paddr = '0;
   logic [DATA_BITS-1:0] pwdata = '0;
   logic [DATA_BITS-1:0] prdata;
   logic                 pready;

   box_t        box_queue[$];
   cull_t       expected_culls[$];
   logic [63:0] matrix_rows[ROW_COUNT];
   int          mismatches = 0;
   int          gap_left = 0;
   int          idle_pct = 0;
   box_t        next_box;

   aabb_frustum_cull #(
      .COORD_BITS(COORD_W),
      .COEF_BITS(16)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_box_min_x(req_box_min_x),
      .req_box_min_y(req_box_min_y),
      .req_box_min_z(req_box_min_z),
      .req_box_max_x(req_box_max_x),
      .req_box_max_y(req_box_max_y),
      .req_box_max_z(req_box_max_z),
      .rsp_strobe(rsp_strobe),
      .rsp_visible(rsp_visible),
      .rsp_rejecting_plane(rsp_rejecting_plane),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // p-vertex test against the six planes built from the matrix rows
   function automatic cull_t cull_box(box_t b);
      int          lo[3];
      int          hi[3];
      int          r3[4];
      int          p[4];
      int          e;
      longint      plane_dist;
      logic [63:0] src;
      cull_t       res;
      lo[0] = b.min_x; lo[1] = b.min_y; lo[2] = b.min_z;
      hi[0] = b.max_x; hi[1] = b.max_y; hi[2] = b.max_z;
      for (int c = 0; c < 4; c++) begin
         r3[c] = $signed(matrix_rows[REG_ROW_3][ENTRY_PITCH*c +: 16]);
      end
      res.visible = 1'b1;
      res.plane   = PLANE_NONE;
      for (int k = 0; k < PLANE_COUNT; k++) begin
         src = matrix_rows[k >> 1];
         for (int c = 0; c < 4; c++) begin
            e = $signed(src[ENTRY_PITCH*c +: 16]);
            p[c] = (k & 1) ? r3[c] - e : r3[c] + e;
         end
         plane_dist = p[3];
         for (int c = 0; c < 3; c++) begin
            plane_dist += longint'(p[c]) * longint'(p[c] >= 0 ? hi[c] : lo[c]);
         end
         if (plane_dist < 0) begin
            res.visible = 1'b0;
            res.plane   = plane_code_type'(k);
            break;
         end
      end
      return res;
   endfunction

   function automatic logic [63:0] pack_row(int c0, int c1, int c2, int c3);
      logic [15:0] e0, e1, e2, e3;
      e0 = c0[15:0]; e1 = c1[15:0]; e2 = c2[15:0]; e3 = c3[15:0];
      return {e3, e2, e1, e0};
   endfunction

   function automatic int clamp16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // box around a region sized per axis, sometimes raw bits, sometimes inverted
   function automatic box_t random_box(int ext0, int ext1, int ext2);
      box_t b;
      int   ext[3];
      int   lo[3];
      int   hi[3];
      int   ctr;
      int   half;
      int   tmp;
      int   ax;
      ext[0] = ext0; ext[1] = ext1; ext[2] = ext2;
      if ($urandom_range(7) == 0) begin
         b = {$urandom, $urandom, $urandom};
         return b;
      end
      for (int a = 0; a < 3; a++) begin
         ctr = int'($urandom_range(0, 4*ext[a])) - 2*ext[a];
         half = $urandom_range(0, ext[a]/2 + 1);
         lo[a] = clamp16(ctr - half);
         hi[a] = clamp16(ctr + half);
      end
      if ($urandom_range(15) == 0) begin
         ax = $urandom_range(2);
         tmp = lo[ax]; lo[ax] = hi[ax]; hi[ax] = tmp;
      end
      b.min_x = lo[0]; b.min_y = lo[1]; b.min_z = lo[2];
      b.max_x = hi[0]; b.max_y = hi[1]; b.max_z = hi[2];
      return b;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || busy === 1'b0) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (box_queue.size() > 0) begin
            next_box = box_queue.pop_front();
            req_box_min_x <= next_box.min_x;
            req_box_min_y <= next_box.min_y;
            req_box_min_z <= next_box.min_z;
            req_box_max_x <= next_box.max_x;
            req_box_max_y <= next_box.max_y;
            req_box_max_z <= next_box.max_z;
            start <= 1'b1;
            if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
               gap_left <= $urandom_range(1, 17);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // result monitor and prediction at request acceptance
   always @(posedge clock) begin
      cull_t want;
      box_t  taken;
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            if (expected_culls.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%t: unexpected result visible=%b plane=%0d", $time,
                           rsp_visible, rsp_rejecting_plane);
               end
            end else begin
               want = expected_culls.pop_front();
               if (rsp_visible !== want.visible || rsp_rejecting_plane !== want.plane) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%t: mismatch visible exp %b got %b, plane exp %0d got %0d",
                              $time, want.visible, rsp_visible, want.plane,
                              rsp_rejecting_plane);
                  end
               end
            end
         end
         if (start && busy === 1'b0) begin
            taken.min_x = req_box_min_x; taken.min_y = req_box_min_y;
            taken.min_z = req_box_min_z; taken.max_x = req_box_max_x;
            taken.max_y = req_box_max_y; taken.max_z = req_box_max_z;
            expected_culls.push_back(cull_box(taken));
         end
      end
   end

   task automatic write_row(reg_index_type idx, logic [63:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      matrix_rows[idx] = value;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic load_matrix(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
                              logic [63:0] r3);
      write_row(REG_ROW_0, r0);
      write_row(REG_ROW_1, r1);
      write_row(REG_ROW_2, r2);
      write_row(REG_ROW_3, r3);
      @(negedge clock);
   endtask

   task automatic queue_box(int x0, int y0, int z0, int x1, int y1, int z1);
      box_t b;
      b.min_x = x0; b.min_y = y0; b.min_z = z0;
      b.max_x = x1; b.max_y = y1; b.max_z = z1;
      box_queue.push_back(b);
   endtask

   // wait until every request is in and every result is back
   task automatic drain();
      do @(negedge clock); while (box_queue.size() > 0 || start || expected_culls.size() > 0);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [63:0] pattern_row();
      case ($urandom_range(4))
         0: return '0;
         1: return '1;
         2: return {4{16'h8000}};
         3: return {4{16'h7fff}};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      int s[3];
      int t[3];
      int w;
      int ext[3];
      int span;
      int n_phases;
      for (int r = 0; r < ROW_COUNT; r++) matrix_rows[r] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset matrix: zero normals, every plane reduces to d >= 0
      queue_box(-32768, -32768, -32768, -32768, -32768, -32768);
      queue_box(32767, 32767, 32767, 32767, 32767, 32767);
      drain();

      // axis-aligned box frustum, |x|,|y|,|z| <= 100
      load_matrix(pack_row(256, 0, 0, 0), pack_row(0, 256, 0, 0),
                  pack_row(0, 0, 256, 0), pack_row(0, 0, 0, 25600));
      queue_box(-10, -10, -10, 10, 10, 10);
      queue_box(-300, 0, 0, -200, 0, 0);
      queue_box(200, 0, 0, 300, 0, 0);
      queue_box(0, -300, 0, 0, -200, 0);
      queue_box(0, 200, 0, 0, 300, 0);
      queue_box(0, 0, -300, 0, 0, -200);
      queue_box(0, 0, 200, 0, 0, 300);
      queue_box(-150, 0, 0, -100, 0, 0);
      queue_box(200, 0, 0, -200, 0, 0);
      queue_box(-32768, -32768, -32768, -32768, -32768, -32768);
      queue_box(32767, 32767, 32767, 32767, 32767, 32767);
      queue_box(-32768, -32768, -32768, 32767, 32767, 32767);
      drain();

      // extreme coefficients
      load_matrix({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h7fff}});
      queue_box(-32768, -32768, -32768, 32767, 32767, 32767);
      queue_box(32767, -32768, 32767, -32768, 32767, -32768);
      queue_box(0, 0, 0, 0, 0, 0);
      drain();
      load_matrix('1, '1, '1, '1);
      queue_box(-32768, -32768, -32768, 32767, 32767, 32767);
      queue_box(1, 1, 1, 1, 1, 1);
      queue_box(-1, -1, -1, -1, -1, -1);
      drain();

      n_phases = 12;
      for (int ph = 0; ph < n_phases; ph++) begin
         idle_pct = (ph == n_phases - 1 || ph % 3 == 2) ? 0 : $urandom_range(10, 40);
         span = 1 << $urandom_range(4, 14);
         ext[0] = span; ext[1] = span; ext[2] = span;
         case (ph % 4)
            0: begin
               w = $urandom_range(4096, 32767);
               for (int a = 0; a < 3; a++) begin
                  s[a] = $urandom_range(16, 1024);
                  if ($urandom_range(3) == 0) s[a] = -s[a];
                  t[a] = int'($urandom_range(0, w/2)) - w/4;
                  ext[a] = w / (s[a] < 0 ? -s[a] : s[a]) + 1;
               end
               load_matrix(pack_row(s[0], 0, 0, t[0]), pack_row(0, s[1], 0, t[1]),
                           pack_row(0, 0, s[2], t[2]), pack_row(0, 0, 0, w));
            end
            1: begin
               load_matrix(pack_row($urandom_range(256, 8192), 0, 0, 0),
                           pack_row(0, $urandom_range(256, 8192), 0, 0),
                           pack_row(0, 0, int'($urandom_range(0, 8192)) - 4096,
                                    int'($urandom_range(0, 32767)) - 16384),
                           pack_row(0, 0, -int'($urandom_range(16, 4096)),
                                    $urandom_range(0, 4096)));
            end
            2: begin
               load_matrix({$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom}, {$urandom, $urandom});
            end
            default: begin
               load_matrix(pattern_row(), pattern_row(), pattern_row(), pattern_row());
            end
         endcase
         repeat (62) box_queue.push_back(random_box(ext[0], ext[1], ext[2]));
         drain();
      end

      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_culls.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== files.f =====
hdl/afc_pkg.sv
hdl/afc_plane_regs.sv
hdl/afc_plane_test.sv
hdl/aabb_frustum_cull.sv
bench/tb_aabb_frustum_cull.sv
